// ----- hw/rtl/lms_echo_canceller_unit_defines.svh -----
// assertion macros for the lms echo canceller
`ifndef LMS_ECHO_CANCELLER_UNIT_DEFINES_SVH
`define LMS_ECHO_CANCELLER_UNIT_DEFINES_SVH

// same-cycle implication
`define LEC_ASSERT_IMP(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define LEC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/lec_pkg.sv -----
// shared constants for the lms echo canceller
`timescale 1ns / 1ps

package lec_pkg;

    localparam int TAPS       = 1024;
    localparam int HIST_DEPTH = 16384;
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 24;
    localparam int SFRAC      = SAMPLE_W - 1;
    localparam int WFRAC      = WEIGHT_W - 4;
    localparam int STEP_W     = 16;
    localparam int UPD_SHIFT  = STEP_W + 2 * SFRAC - WFRAC;

    localparam int DELAY_W    = 14;
    localparam int LIMIT_W    = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;

    localparam int MUE_W      = STEP_W + SAMPLE_W + 1;
    localparam int PROD_W     = MUE_W + SAMPLE_W;
    localparam int ACC_W      = 64;
    localparam int DELTA_W    = PROD_W + 1 - UPD_SHIFT;
    localparam int MAX_LW     = (LIMIT_W > WEIGHT_W) ? LIMIT_W : WEIGHT_W;
    localparam int CLAMP_W    = ((MAX_LW > DELTA_W) ? MAX_LW : DELTA_W) + 2;

    localparam int TAP_AW     = $clog2(TAPS);
    localparam int TAP_CW     = $clog2(TAPS + 1);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_REF_DELAY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT = CFG_IDX_W'(2);

    localparam logic [DELAY_W-1:0] RESET_REF_DELAY    = '0;
    localparam logic [STEP_W-1:0]  RESET_STEP_SIZE    = STEP_W'(32768);
    localparam logic [LIMIT_W-1:0] RESET_WEIGHT_LIMIT = LIMIT_W'(5242880);

    localparam logic signed [ACC_W:0] ERR_HALF = (ACC_W + 1)'(1) << (WFRAC - 1);
    localparam logic signed [ACC_W:0] SMAX_EXT = (ACC_W + 1)'((1 << SFRAC) - 1);
    localparam logic signed [ACC_W:0] SMIN_EXT = -((ACC_W + 1)'(1) << SFRAC);
    localparam logic signed [SAMPLE_W-1:0] SMAX = SAMPLE_W'((1 << SFRAC) - 1);
    localparam logic signed [SAMPLE_W-1:0] SMIN = SAMPLE_W'(1) << SFRAC;

    localparam logic signed [PROD_W:0] UPD_HALF = (PROD_W + 1)'(1) << (UPD_SHIFT - 1);
    localparam logic signed [CLAMP_W-1:0] WMAX_C = (CLAMP_W'(1) << (WEIGHT_W - 1)) - 1'b1;

endpackage

// ----- hw/rtl/lec_ram.sv -----
// simple dual-port ram with registered read
`timescale 1ns / 1ps

module lec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/lec_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module lec_mul (
    input  logic                              clk,
    input  logic signed [lec_pkg::MUE_W-1:0]    a,
    input  logic signed [lec_pkg::SAMPLE_W-1:0] b,
    output logic signed [lec_pkg::PROD_W-1:0]   p
);

    logic signed [lec_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= lec_pkg::PROD_W'(a) * lec_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/lms_echo_canceller_unit.sv -----
// lms echo canceller top level: sequencer, history and weight memories
// One word in gives one word out. Each word is handled alone: the block takes it, then
// runs one filter pass and one weight update pass over all TAPS taps through a single
// shared multiplier fed from the history and weight memories, one tap per cycle. A word
// goes from acceptance through the filter pass, the error and step states and the update
// pass until its result is loaded into the output register, which waits while an older
// result is still held there; no new word is taken before that, and the next word is
// taken as soon as that is done, even while the result still waits. History entries never
// written read as zero (tracked by write position and a wrap flag) and weights read as zero
// until the first word has finished, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`include "lms_echo_canceller_unit_defines.svh"

module lms_echo_canceller_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lec_pkg::SAMPLE_W-1:0]  speaker_sample,
    input  logic signed [lec_pkg::SAMPLE_W-1:0]  mic_sample,
    input  logic                                 block_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lec_pkg::SAMPLE_W-1:0]  error_sample,
    output logic                                 block_end_out,
    input  logic                                 cfg_write,
    input  logic [lec_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lec_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ERR1,
        S_ERR2,
        S_MUE,
        S_MULW,
        S_UPD,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [lec_pkg::TAP_CW-1:0]          cnt_reg, cnt_next;
    logic                                v1_reg, v1_next;
    logic                                v2_reg, v2_next;
    logic                                hok1_reg, hok1_next;
    logic [lec_pkg::TAP_AW-1:0]          idx1_reg, idx1_next;
    logic [lec_pkg::TAP_AW-1:0]          idx2_reg, idx2_next;
    logic signed [lec_pkg::WEIGHT_W-1:0] w2_reg, w2_next;
    logic signed [lec_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [lec_pkg::ACC_W-1:0]    efull_reg, efull_next;
    logic signed [lec_pkg::SAMPLE_W-1:0] e_reg, e_next;
    logic signed [lec_pkg::MUE_W-1:0]    mue_reg, mue_next;
    logic [lec_pkg::HIST_AW-1:0]         base_reg, base_next;
    logic [lec_pkg::HIST_AW-1:0]         wp_reg, wp_next;
    logic                                wrapped_reg, wrapped_next;
    logic                                wvalid_reg, wvalid_next;
    logic signed [lec_pkg::SAMPLE_W-1:0] mic_reg, mic_next;
    logic                                be_reg, be_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [lec_pkg::SAMPLE_W-1:0] err_out_reg, err_out_next;
    logic                                be_out_reg, be_out_next;
    logic [lec_pkg::DELAY_W-1:0]         delay_reg, delay_next;
    logic [lec_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [lec_pkg::LIMIT_W-1:0]         wlim_reg, wlim_next;

    logic                                in_acc;
    logic                                issuing;
    logic                                pass_done;
    logic [lec_pkg::HIST_AW-1:0]         haddr;
    logic                                hok0;
    logic [lec_pkg::SAMPLE_W-1:0]        h_rd;
    logic [lec_pkg::WEIGHT_W-1:0]        w_rd;
    logic signed [lec_pkg::WEIGHT_W-1:0] wq;
    logic signed [lec_pkg::SAMPLE_W-1:0] xq;
    logic signed [lec_pkg::MUE_W-1:0]    mul_a;
    logic signed [lec_pkg::SAMPLE_W-1:0] mul_b;
    logic signed [lec_pkg::PROD_W-1:0]   prod;
    logic signed [lec_pkg::ACC_W:0]      err_rnd;
    logic signed [lec_pkg::ACC_W:0]      err_sh;
    logic signed [lec_pkg::SAMPLE_W-1:0] e_sat;
    logic signed [lec_pkg::PROD_W:0]     upd_rnd;
    logic signed [lec_pkg::PROD_W:0]     upd_sh;
    logic signed [lec_pkg::CLAMP_W-1:0]  wsum;
    logic signed [lec_pkg::CLAMP_W-1:0]  lim_raw;
    logic signed [lec_pkg::CLAMP_W-1:0]  lim;
    logic signed [lec_pkg::CLAMP_W-1:0]  wnew;
    logic                                w_we;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_acc        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign error_sample  = err_out_reg;
    assign block_end_out = be_out_reg;

    // tap address walks back from the newest sample less the delay
    assign issuing   = ((state_reg == S_MAC) || (state_reg == S_UPD))
                       && (cnt_reg < lec_pkg::TAP_CW'(lec_pkg::TAPS));
    assign pass_done = (cnt_reg == lec_pkg::TAP_CW'(lec_pkg::TAPS)) && !v1_reg && !v2_reg;
    assign haddr     = base_reg - lec_pkg::HIST_AW'(cnt_reg);
    assign hok0      = wrapped_reg || (haddr <= wp_reg);

    lec_ram #(
        .WIDTH (lec_pkg::SAMPLE_W),
        .DEPTH (lec_pkg::HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (wp_reg),
        .wr_data (speaker_sample),
        .rd_addr (haddr),
        .rd_data (h_rd)
    );

    lec_ram #(
        .WIDTH (lec_pkg::WEIGHT_W),
        .DEPTH (lec_pkg::TAPS)
    ) u_weights (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (idx2_reg),
        .wr_data (wnew[lec_pkg::WEIGHT_W-1:0]),
        .rd_addr (cnt_reg[lec_pkg::TAP_AW-1:0]),
        .rd_data (w_rd)
    );

    assign wq = wvalid_reg ? signed'(w_rd) : '0;
    assign xq = hok1_reg ? signed'(h_rd) : '0;

    always_comb
    begin
        if (state_reg == S_MUE)
        begin
            mul_a = signed'(lec_pkg::MUE_W'(step_reg));
            mul_b = e_reg;
        end
        else if (state_reg == S_UPD)
        begin
            mul_a = mue_reg;
            mul_b = xq;
        end
        else
        begin
            mul_a = lec_pkg::MUE_W'(wq);
            mul_b = xq;
        end
    end

    lec_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // error rounding and saturation
    always_comb
    begin
        err_rnd = (lec_pkg::ACC_W + 1)'(efull_reg) + lec_pkg::ERR_HALF;
        err_sh  = err_rnd >>> lec_pkg::WFRAC;
        if (err_sh > lec_pkg::SMAX_EXT)
        begin
            e_sat = lec_pkg::SMAX;
        end
        else if (err_sh < lec_pkg::SMIN_EXT)
        begin
            e_sat = lec_pkg::SMIN;
        end
        else
        begin
            e_sat = err_sh[lec_pkg::SAMPLE_W-1:0];
        end
    end

    // weight step, rounding and clamp
    always_comb
    begin
        upd_rnd = (lec_pkg::PROD_W + 1)'(prod) + lec_pkg::UPD_HALF;
        upd_sh  = upd_rnd >>> lec_pkg::UPD_SHIFT;
        wsum    = lec_pkg::CLAMP_W'(w2_reg)
                  + lec_pkg::CLAMP_W'(signed'(upd_sh[lec_pkg::DELTA_W-1:0]));
        lim_raw = signed'(lec_pkg::CLAMP_W'(wlim_reg));
        lim     = (lim_raw > lec_pkg::WMAX_C) ? lec_pkg::WMAX_C : lim_raw;
        if (wsum > lim)
        begin
            wnew = lim;
        end
        else if (wsum < -lim)
        begin
            wnew = -lim;
        end
        else
        begin
            wnew = wsum;
        end
    end

    assign w_we = (state_reg == S_UPD) && v2_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        v1_next        = issuing;
        v2_next        = v1_reg;
        hok1_next      = hok0;
        idx1_next      = cnt_reg[lec_pkg::TAP_AW-1:0];
        idx2_next      = idx1_reg;
        w2_next        = wq;
        acc_next       = acc_reg;
        efull_next     = efull_reg;
        e_next         = e_reg;
        mue_next       = mue_reg;
        base_next      = base_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        wvalid_next    = wvalid_reg;
        mic_next       = mic_reg;
        be_next        = be_reg;
        out_valid_next = out_valid_reg && !out_ready;
        err_out_next   = err_out_reg;
        be_out_next    = be_out_reg;
        delay_next     = delay_reg;
        step_next      = step_reg;
        wlim_next      = wlim_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                lec_pkg::REG_REF_DELAY:    delay_next = cfg_data[lec_pkg::DELAY_W-1:0];
                lec_pkg::REG_STEP_SIZE:    step_next  = cfg_data[lec_pkg::STEP_W-1:0];
                lec_pkg::REG_WEIGHT_LIMIT: wlim_next  = cfg_data[lec_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end

        if (issuing)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mic_next   = mic_sample;
                    be_next    = block_end;
                    base_next  = wp_reg - lec_pkg::HIST_AW'(delay_reg);
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (v2_reg)
                begin
                    acc_next = acc_reg + lec_pkg::ACC_W'(prod);
                end
                if (pass_done)
                begin
                    state_next = S_ERR1;
                end
            end
            S_ERR1:
            begin
                efull_next = (lec_pkg::ACC_W'(mic_reg) <<< lec_pkg::WFRAC) - acc_reg;
                state_next = S_ERR2;
            end
            S_ERR2:
            begin
                e_next     = e_sat;
                state_next = S_MUE;
            end
            S_MUE:
            begin
                state_next = S_MULW;
            end
            S_MULW:
            begin
                mue_next   = prod[lec_pkg::MUE_W-1:0];
                cnt_next   = '0;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (pass_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    err_out_next   = e_reg;
                    be_out_next    = be_reg;
                    wp_next        = wp_reg + 1'b1;
                    wvalid_next    = 1'b1;
                    if (wp_reg == lec_pkg::HIST_AW'(lec_pkg::HIST_DEPTH - 1))
                    begin
                        wrapped_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            hok1_reg      <= 1'b0;
            idx1_reg      <= '0;
            idx2_reg      <= '0;
            w2_reg        <= '0;
            acc_reg       <= '0;
            efull_reg     <= '0;
            e_reg         <= '0;
            mue_reg       <= '0;
            base_reg      <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            wvalid_reg    <= 1'b0;
            mic_reg       <= '0;
            be_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            err_out_reg   <= '0;
            be_out_reg    <= 1'b0;
            delay_reg     <= lec_pkg::RESET_REF_DELAY;
            step_reg      <= lec_pkg::RESET_STEP_SIZE;
            wlim_reg      <= lec_pkg::RESET_WEIGHT_LIMIT;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            hok1_reg      <= hok1_next;
            idx1_reg      <= idx1_next;
            idx2_reg      <= idx2_next;
            w2_reg        <= w2_next;
            acc_reg       <= acc_next;
            efull_reg     <= efull_next;
            e_reg         <= e_next;
            mue_reg       <= mue_next;
            base_reg      <= base_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            wvalid_reg    <= wvalid_next;
            mic_reg       <= mic_next;
            be_reg        <= be_next;
            out_valid_reg <= out_valid_next;
            err_out_reg   <= err_out_next;
            be_out_reg    <= be_out_next;
            delay_reg     <= delay_next;
            step_reg      <= step_next;
            wlim_reg      <= wlim_next;
        end
    end

    // sequencer checks
    `LEC_ASSERT_NEXT(a_busy_after_word, clk, rst_n, in_acc, !in_ready, "ready after word taken")
    `LEC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= lec_pkg::TAP_CW'(lec_pkg::TAPS), "tap count overrun")
    `LEC_ASSERT_IMP(a_pipe_in_pass, clk, rst_n, v2_reg, (state_reg == S_MAC) || (state_reg == S_UPD), "tap pipe active outside a pass")
    `LEC_ASSERT_NEXT(a_fin_holds, clk, rst_n, (state_reg == S_FIN) && out_valid_reg && !out_ready, state_reg == S_FIN, "result overwritten while waiting")

endmodule
